// ===== hdl/page_bitmap_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Page bitmap allocator assertion macros
// Clocked property wrappers shared by the allocator's checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is low.
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Status and operation codes, register indexes and the sequencer microcode.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_PAGE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic REG_BITMAP_BYTES = 1'b0;
	localparam logic REG_BASE_ADDRESS = 1'b1;

	localparam logic [12:0] RESET_BITMAP_BYTES = 13'd4096;
	localparam logic [31:0] RESET_BASE_ADDRESS = 32'h0012_0000;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE     = 4'd0;
	localparam step_t STEP_DISPATCH = 4'd1;
	localparam step_t STEP_A_RD     = 4'd2;
	localparam step_t STEP_A_TEST   = 4'd3;
	localparam step_t STEP_A_MUL    = 4'd4;
	localparam step_t STEP_A_ADD    = 4'd5;
	localparam step_t STEP_A_NONE   = 4'd6;
	localparam step_t STEP_F_SUB    = 4'd7;
	localparam step_t STEP_F_DIV    = 4'd8;
	localparam step_t STEP_F_CHK    = 4'd9;
	localparam step_t STEP_F_RD     = 4'd10;
	localparam step_t STEP_F_WR     = 4'd11;
	localparam step_t STEP_F_BAD    = 4'd12;
	localparam step_t STEP_EMIT     = 4'd13;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_TEST,
		ACT_MUL,
		ACT_ADDR,
		ACT_NOPAGE,
		ACT_SUB,
		ACT_DIV,
		ACT_FIDX,
		ACT_CLR,
		ACT_BAD,
		ACT_EMIT
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_FREE,
		C_SCAN_END,
		C_BYTE_FULL,
		C_BELOW,
		C_RANGE_BAD,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t hold;
		cond_t jump;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t cw;
		cw = '{act: ACT_NONE, hold: C_NEVER, jump: C_NEVER, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE:     cw = '{ACT_LOAD,   C_NO_REQ,   C_NEVER,     STEP_IDLE};
			STEP_DISPATCH: cw = '{ACT_NONE,   C_NEVER,    C_FREE,      STEP_F_SUB};
			STEP_A_RD:     cw = '{ACT_NONE,   C_NEVER,    C_SCAN_END,  STEP_A_NONE};
			STEP_A_TEST:   cw = '{ACT_TEST,   C_NEVER,    C_BYTE_FULL, STEP_A_RD};
			STEP_A_MUL:    cw = '{ACT_MUL,    C_NEVER,    C_NEVER,     STEP_IDLE};
			STEP_A_ADD:    cw = '{ACT_ADDR,   C_NEVER,    C_ALWAYS,    STEP_EMIT};
			STEP_A_NONE:   cw = '{ACT_NOPAGE, C_NEVER,    C_ALWAYS,    STEP_EMIT};
			STEP_F_SUB:    cw = '{ACT_SUB,    C_NEVER,    C_BELOW,     STEP_F_BAD};
			STEP_F_DIV:    cw = '{ACT_DIV,    C_NEVER,    C_NEVER,     STEP_IDLE};
			STEP_F_CHK:    cw = '{ACT_FIDX,   C_NEVER,    C_RANGE_BAD, STEP_F_BAD};
			STEP_F_RD:     cw = '{ACT_NONE,   C_NEVER,    C_NEVER,     STEP_IDLE};
			STEP_F_WR:     cw = '{ACT_CLR,    C_NEVER,    C_ALWAYS,    STEP_EMIT};
			STEP_F_BAD:    cw = '{ACT_BAD,    C_NEVER,    C_NEVER,     STEP_IDLE};
			STEP_EMIT:     cw = '{ACT_EMIT,   C_OUT_BUSY, C_ALWAYS,    STEP_IDLE};
			default:       cw = '{ACT_NONE,   C_NEVER,    C_ALWAYS,    STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

// ===== hdl/page_bitmap_allocator_unit.sv =====
// Allocate scans the map bytes in order; the scan reads at most min(bitmap_bytes,
// PAGE_COUNT/8) bytes. Free ends early when the page number is out of range, and
// earlier still when the address is below base. One request at a time: the next is
// taken in the cycle after the result is registered; a held result stalls it.
// Reset: asynchronous, active low; then a clearing pass zeroes the map before the
// first item is taken. bitmap_bytes resets to 4096, base to 0x120000.
// ----------------------------------------------------------------------------
// Page bitmap allocator
// Microcoded allocator over a one-bit-per-page map held in a byte-wide memory.
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_unit_assert.svh"

module page_bitmap_allocator_unit
	import pba_pkg::*;
#(
	parameter int PAGE_COUNT = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] page_address
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] alloc_address
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int MAP_DEPTH = PAGE_COUNT / 8;
	localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int CW = $clog2(MAP_DEPTH + 1);
	localparam int NW = CW + 3;
	// page size is a power of two
	localparam int PB_SHIFT = $clog2(PAGE_BYTES);

	// configuration
	logic [12:0] bitmap_bytes_q;
	logic [31:0] base_q;

	// sequencer
	step_t pc_q;
	step_t pc_next;
	ctrl_t cw;
	logic [15:0] cond_vec;
	logic hold_hit;
	logic jump_hit;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	// datapath
	logic          op_q;
	logic [31:0]   addr_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] used_next;
	logic [31:0]   bb_ext;
	logic [31:0]   used_ext;
	logic [CW-1:0] byte_q;
	logic [2:0]    bit_q;
	logic [NW-1:0] num_q;
	logic [31:0]   prod_q;
	logic [31:0]   quo_q;
	logic [31:0]   quo_m1;
	logic [2:0]    free_bit;
	logic [7:0]    free_mask;
	logic          byte_full;
	logic          range_bad;
	logic          accept;
	logic          out_busy;
	logic [31:0]   res_addr_q;
	logic [1:0]    res_st_q;

	// map memory
	logic [7:0]    mem [MAP_DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;

	// output register
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [1:0]  out_st_q;

	assign s_tready = (pc_q == STEP_IDLE) && !clr_q;
	assign accept   = s_tvalid && s_tready;
	assign out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_st_q;

	// clamp the map size to the storage
	assign bb_ext    = 32'(bitmap_bytes_q);
	assign used_ext  = (bb_ext > 32'(MAP_DEPTH)) ? 32'(MAP_DEPTH) : bb_ext;
	assign used_next = used_ext[CW-1:0];

	assign byte_full = (rdata_q == 8'hFF);
	assign quo_m1    = quo_q - 32'd1;
	assign range_bad = (quo_q == 32'd0) || (quo_q > 32'({used_q, 3'b000}));

	always_comb begin
		free_bit = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!rdata_q[i]) begin
				free_bit = 3'(i);
			end
		end
	end

	assign free_mask = 8'd1 << free_bit;

	always_comb begin
		cond_vec              = '0;
		cond_vec[C_NEVER]     = 1'b0;
		cond_vec[C_ALWAYS]    = 1'b1;
		cond_vec[C_NO_REQ]    = !accept;
		cond_vec[C_FREE]      = (op_q == OP_FREE);
		cond_vec[C_SCAN_END]  = (byte_q >= used_q);
		cond_vec[C_BYTE_FULL] = byte_full;
		cond_vec[C_BELOW]     = (addr_q < base_q);
		cond_vec[C_RANGE_BAD] = range_bad;
		cond_vec[C_OUT_BUSY]  = out_busy;
	end

	always_comb begin
		cw       = ucode_rom(pc_q);
		hold_hit = cond_vec[cw.hold];
		jump_hit = cond_vec[cw.jump];
		if (hold_hit) begin
			pc_next = pc_q;
		end else if (jump_hit) begin
			pc_next = cw.target;
		end else begin
			pc_next = pc_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_bytes_q <= RESET_BITMAP_BYTES;
			base_q         <= RESET_BASE_ADDRESS;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BITMAP_BYTES: bitmap_bytes_q <= cfg_wdata[12:0];
				REG_BASE_ADDRESS: base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(MAP_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// map write port: clearing pass, set on allocate, clear on free
	always_comb begin
		mem_we = 1'b0;
		mem_wa = byte_q[AW-1:0];
		mem_wd = rdata_q;
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = 8'h00;
		end else if (cw.act == ACT_TEST && !byte_full) begin
			mem_we = 1'b1;
			mem_wd = rdata_q | free_mask;
		end else if (cw.act == ACT_CLR) begin
			mem_we = 1'b1;
			mem_wd = rdata_q & ~(8'd1 << bit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[byte_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		case (cw.act)
			ACT_LOAD: begin
				if (accept) begin
					op_q   <= s_tuser;
					addr_q <= s_tdata;
					used_q <= used_next;
					byte_q <= '0;
				end
			end
			ACT_TEST: begin
				if (byte_full) begin
					byte_q <= byte_q + CW'(1);
				end else begin
					num_q <= {byte_q, free_bit} + NW'(1);
				end
			end
			ACT_MUL: prod_q <= 32'(32'(num_q) * 32'(PAGE_BYTES));
			ACT_ADDR: begin
				res_addr_q <= base_q + prod_q;
				res_st_q   <= ST_OK;
			end
			ACT_NOPAGE: begin
				res_addr_q <= '0;
				res_st_q   <= ST_NO_PAGE;
			end
			ACT_SUB: begin
				quo_q <= addr_q - base_q;
			end
			ACT_DIV: begin
				// floor division by the page size
				quo_q <= quo_q >> PB_SHIFT;
			end
			ACT_FIDX: begin
				byte_q <= quo_m1[CW+2:3];
				bit_q  <= quo_m1[2:0];
			end
			ACT_CLR: begin
				res_addr_q <= '0;
				res_st_q   <= ST_OK;
			end
			ACT_BAD: begin
				res_addr_q <= '0;
				res_st_q   <= ST_INVALID;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.act == ACT_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.act == ACT_EMIT && !out_busy) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	`PBA_ASSERT_NOW(a_clear_idle, clk, arst_n, clr_q, pc_q == STEP_IDLE, "sequencer left idle during map clear")
	`PBA_ASSERT_NOW(a_scan_bound, clk, arst_n, pc_q == STEP_A_TEST, byte_q < used_q, "scan beyond map bytes in use")
	`PBA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_busy, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives allocate and free requests through the request stream with random
// gaps and back-pressure. A shadow of the page map predicts every reply, and
// each reply beat is compared field by field. The run starts with a table of
// directed requests: extremes, an empty map, a full map, and out-of-range
// frees. It then walks random phases, each of which may retune map size and base.
// ----------------------------------------------------------------------------
module tb;
	import pba_pkg::*;

	localparam int unsigned PAGE_COUNT   = 32768;
	localparam int unsigned PAGE_BYTES   = 4096;
	localparam int unsigned MAP_DEPTH    = PAGE_COUNT / 8;
	localparam int          RANDOM_ITEMS = 1875;
	localparam int          CYCLE_LIMIT  = 80_000_000;

	typedef struct packed {
		logic [31:0] address;
		logic [1:0]  status;
	} page_reply_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// sel is the operation for an item row and the register index for a register row
	typedef struct packed {
		row_kind_t   kind;
		logic        sel;
		logic [31:0] value;
		logic        typed;
		logic [31:0] want_address;
		logic [1:0]  want_status;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // [31:0] page_address
	logic        s_tuser   = 1'b0; // [0] operation
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [31:0] alloc_address
	logic [1:0]  m_tuser;          // [1:0] status

	// shadow of the allocator
	logic [7:0]  frame_bits [MAP_DEPTH];
	logic [12:0] map_bytes_cfg;
	logic [31:0] map_base_cfg;

	page_reply_t awaited_replies [$];
	stim_row_t   directed_rows [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          gap_pct        = 30;
	int          stall_pct      = 30;
	int          stall_left     = 0;

	page_bitmap_allocator_unit #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	function automatic int unsigned scan_bytes();
		return (map_bytes_cfg > MAP_DEPTH) ? MAP_DEPTH : int'(map_bytes_cfg);
	endfunction

	function automatic page_reply_t predict_page_reply(input logic op, input logic [31:0] addr);
		page_reply_t res;
		int unsigned n;
		int unsigned number;
		int b;
		n = scan_bytes();
		res.address = '0;
		res.status  = ST_NO_PAGE;
		if (op == OP_ALLOC) begin
			for (int unsigned i = 0; i < n; i++) begin
				if (frame_bits[i] != 8'hFF) begin
					b = 0;
					while (frame_bits[i][b])
						b++;
					frame_bits[i][b] = 1'b1;
					number = i * 8 + b + 1;
					res.address = map_base_cfg + 32'(number * PAGE_BYTES);
					res.status  = ST_OK;
					break;
				end
			end
		end else if (addr < map_base_cfg) begin
			res.status = ST_INVALID;
		end else begin
			number = (addr - map_base_cfg) / PAGE_BYTES;
			if (number == 0 || number > n * 8) begin
				res.status = ST_INVALID;
			end else begin
				frame_bits[(number - 1) >> 3][(number - 1) & 7] = 1'b0;
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		if (idx == REG_BITMAP_BYTES)
			map_bytes_cfg = value[12:0];
		else
			map_base_cfg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid and hold until every reply has been taken
	task automatic wait_results_done();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_request(input logic op, input logic [31:0] addr, input logic typed,
			input page_reply_t want);
		page_reply_t predicted;
		int gap;
		gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= addr;
		do @(posedge clk); while (!s_tready);
		predicted = predict_page_reply(op, addr);
		awaited_replies.push_back(typed ? want : predicted);
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			m_tready   <= 1'b0;
			stall_left <= pick_gap() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		page_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: reply beat with none awaited, expected nothing, actual %h / %0d",
					$time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (m_tdata !== want.address) begin
					$display("%0t: alloc_address expected %h, actual %h",
						$time, want.address, m_tdata);
					mismatch_count++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, want.status, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t   row;
		int          random_sent;
		int          phase_len;
		int          alloc_pct;
		int          r;
		int unsigned span;
		int unsigned number;
		logic        op;
		logic [31:0] addr;
		logic [31:0] new_value;

		for (int i = 0; i < MAP_DEPTH; i++)
			frame_bits[i] = 8'h00;
		map_bytes_cfg = RESET_BITMAP_BYTES;
		map_base_cfg  = RESET_BASE_ADDRESS;

		// reset values: full-size map of 4096 bytes, base 0x120000
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'h0012_1000, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'h0012_2000, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_1000, 1'b1, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'h0012_1000, ST_OK});
		// offset inside the page rounds down
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_1FFF, 1'b1, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0000_0000, 1'b1, 32'h0, ST_INVALID});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_0FFF, 1'b1, 32'h0, ST_INVALID});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_INVALID});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_2000, 1'b1, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_2000, 1'b1, 32'h0, ST_OK});
		// last page of the map, then one past it
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0812_0000, 1'b1, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0812_1000, 1'b1, 32'h0, ST_INVALID});
		// empty map
		directed_rows.push_back('{ROW_REG, REG_BITMAP_BYTES, 32'd0, 1'b0, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'h0, ST_NO_PAGE});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0012_1000, 1'b1, 32'h0, ST_INVALID});
		// one byte at base zero: fill it, then overflow
		directed_rows.push_back('{ROW_REG, REG_BITMAP_BYTES, 32'd1, 1'b0, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_REG, REG_BASE_ADDRESS, 32'h0, 1'b0, 32'h0, ST_OK});
		for (int p = 1; p <= 8; p++)
			directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'(p * PAGE_BYTES),
				ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'h0, 1'b1, 32'h0, ST_NO_PAGE});
		// oversized map and top base: alloc wraps past byte zero's stale bits
		directed_rows.push_back('{ROW_REG, REG_BITMAP_BYTES, 32'd8191, 1'b0, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_REG, REG_BASE_ADDRESS, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_ALLOC, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_INVALID});
		directed_rows.push_back('{ROW_ITEM, OP_FREE, 32'h0000_0000, 1'b1, 32'h0, ST_INVALID});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.kind == ROW_REG) begin
				wait_results_done();
				write_reg(row.sel, row.value);
			end else begin
				send_request(row.sel, row.value, row.typed, '{row.want_address, row.want_status});
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_results_done();
			if ($urandom_range(0, 99) < 80) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					new_value = 0;
				else if (r < 12)
					new_value = 4096;
				else if (r < 16)
					new_value = 8191;
				else if (r < 22)
					new_value = $urandom_range(17, 8191);
				else
					new_value = $urandom_range(1, 16);
				write_reg(REG_BITMAP_BYTES, new_value);
			end
			if ($urandom_range(0, 99) < 60) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					new_value = 32'h0;
				else if (r < 18)
					new_value = 32'hFFFF_FFFF;
				else if (r < 30)
					new_value = RESET_BASE_ADDRESS;
				else if (r < 60)
					new_value = $urandom() & 32'hFFFF_F000;
				else
					new_value = $urandom();
				write_reg(REG_BASE_ADDRESS, new_value);
			end
			gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
			alloc_pct = $urandom_range(25, 75);
			phase_len = $urandom_range(40, 160);
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 2)
					wait_results_done();
				span = scan_bytes() * 8;
				if ($urandom_range(0, 99) < alloc_pct) begin
					op   = OP_ALLOC;
					addr = $urandom();
				end else begin
					op = OP_FREE;
					r  = $urandom_range(0, 99);
					if (r < 12) begin
						addr = $urandom();
					end else begin
						if (r < 18)
							number = 0;
						else if (r < 24)
							number = span + 1;
						else if (span == 0)
							number = 1;
						else if (r < 30 || span <= 256)
							number = $urandom_range(1, span);
						else
							number = $urandom_range(1, 256);
						addr = map_base_cfg + 32'(number * PAGE_BYTES)
							+ 32'($urandom_range(0, PAGE_BYTES - 1));
					end
				end
				send_request(op, addr, 1'b0, '0);
				random_sent++;
			end
		end

		wait_results_done();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
